// ===== design/sals_pkg.sv =====
// Package for the sorted-array levels set.
// Holds shared constants, the sequencer state type and the result struct.
package sals_pkg;

  localparam int unsigned LEVELS_DEF = 10;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned COUNT_W    = 10;
  localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_MREAD,
    S_MCOMP,
    S_CREAD,
    S_CWRITE,
    S_SSEL,
    S_SREAD,
    S_SCOMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] key_count;
  } result_t;

endpackage

// ===== design/sals_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module sals_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sals_engine.sv =====
// Sequencer of the levels set: insert by merging levels, search by binary search.
// Depends on sals_pkg; drives the level store and merge buffer RAMs.
module sals_engine #(
  parameter int unsigned LEVELS = sals_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_func,
  input  logic [sals_pkg::KEY_W-1:0] in_key,
  output logic                      in_ready,
  input  logic                      out_free,
  output logic                      res_valid,
  output sals_pkg::result_t         res,
  output logic                      st_we,
  output logic [LEVELS-1:0]         st_waddr,
  output logic [sals_pkg::KEY_W-1:0] st_wdata,
  output logic [LEVELS-1:0]         st_raddr,
  input  logic [sals_pkg::KEY_W-1:0] st_rdata,
  output logic                      bf_we,
  output logic [LEVELS:0]           bf_waddr,
  output logic [sals_pkg::KEY_W-1:0] bf_wdata,
  output logic [LEVELS:0]           bf_raddr,
  input  logic [sals_pkg::KEY_W-1:0] bf_rdata
);

  localparam int unsigned LW = $clog2(LEVELS + 1);
  localparam logic [LEVELS:0] ONE = (LEVELS + 1)'(1);

  sals_pkg::state_t state, state_next;

  logic [LEVELS-1:0] occ;
  logic [LW-1:0]     lvl;
  logic [LW-1:0]     tgt;
  logic              cur;
  logic [LEVELS:0]   x, y, k;
  logic [LEVELS:0]   lo, hi, mid;
  logic [sals_pkg::KEY_W-1:0] key;
  logic              found, status;

  // Derived quantities of the current and target levels.
  logic [LEVELS:0]   n, n_tgt, base, base_tgt;
  logic [LW-1:0]     first_free;
  logic              all_full, take, occ_lvl;
  logic [LW-1:0]     lvl_inc;
  logic [LEVELS-1:0] occ_sh;

  assign n        = ONE << lvl;
  assign n_tgt    = ONE << tgt;
  assign base     = n - ONE;
  assign base_tgt = n_tgt - ONE;
  assign all_full = &occ;
  assign lvl_inc  = lvl + LW'(1);
  assign occ_sh   = occ >> lvl;
  assign occ_lvl  = (lvl < LW'(LEVELS)) ? occ_sh[0] : 1'b0;

  always_comb begin
    first_free = LW'(0);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        first_free = LW'(i);
      end
    end
  end

  // The one shared comparator: stored key against carry or search key.
  logic [sals_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic cmp_le, cmp_eq;
  assign cmp_a  = st_rdata;
  assign cmp_b  = (state == sals_pkg::S_SCOMP) ? key : bf_rdata;
  assign cmp_le = (cmp_a <= cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);
  assign take   = (x < n) && ((y >= n) || cmp_le);

  always_comb begin
    state_next = state;
    unique case (state)
      sals_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_func == sals_pkg::FUNC_SEARCH) begin
            state_next = sals_pkg::S_SSEL;
          end else if (all_full) begin
            state_next = sals_pkg::S_DONE;
          end else begin
            state_next = sals_pkg::S_INIT;
          end
        end
      end
      sals_pkg::S_INIT: begin
        state_next = (tgt == LW'(0)) ? sals_pkg::S_CREAD : sals_pkg::S_MREAD;
      end
      sals_pkg::S_MREAD: state_next = sals_pkg::S_MCOMP;
      sals_pkg::S_MCOMP: begin
        if (k + ONE == (n << 1)) begin
          state_next = (lvl_inc == tgt) ? sals_pkg::S_CREAD : sals_pkg::S_MREAD;
        end else begin
          state_next = sals_pkg::S_MREAD;
        end
      end
      sals_pkg::S_CREAD: state_next = sals_pkg::S_CWRITE;
      sals_pkg::S_CWRITE: begin
        state_next = (k + ONE == n_tgt) ? sals_pkg::S_DONE : sals_pkg::S_CREAD;
      end
      sals_pkg::S_SSEL: begin
        if (lvl == LW'(LEVELS)) begin
          state_next = sals_pkg::S_DONE;
        end else if (occ_lvl) begin
          state_next = sals_pkg::S_SREAD;
        end
      end
      sals_pkg::S_SREAD: begin
        state_next = (lo >= hi) ? sals_pkg::S_SSEL : sals_pkg::S_SCOMP;
      end
      sals_pkg::S_SCOMP: begin
        state_next = cmp_eq ? sals_pkg::S_DONE : sals_pkg::S_SREAD;
      end
      sals_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sals_pkg::S_IDLE;
        end
      end
      default: state_next = sals_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sals_pkg::S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      if (state == sals_pkg::S_CWRITE && k + ONE == n_tgt) begin
        occ <= (occ & ~LEVELS'(n_tgt - ONE)) | LEVELS'(n_tgt);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      sals_pkg::S_IDLE: begin
        key    <= in_key ^ sals_pkg::SIGN_FLIP;
        tgt    <= first_free;
        lvl    <= LW'(0);
        cur    <= 1'b0;
        x      <= '0;
        y      <= '0;
        k      <= '0;
        found  <= 1'b0;
        status <= (in_func == sals_pkg::FUNC_INSERT) && all_full;
      end
      sals_pkg::S_MCOMP: begin
        if (k + ONE == (n << 1)) begin
          cur <= ~cur;
          lvl <= lvl_inc;
          x   <= '0;
          y   <= '0;
          k   <= '0;
        end else begin
          k <= k + ONE;
          if (take) begin
            x <= x + ONE;
          end else begin
            y <= y + ONE;
          end
        end
      end
      sals_pkg::S_CWRITE: k <= k + ONE;
      sals_pkg::S_SSEL: begin
        lo <= '0;
        hi <= n;
        if (!occ_lvl && lvl != LW'(LEVELS)) begin
          lvl <= lvl_inc;
        end
      end
      sals_pkg::S_SREAD: begin
        mid <= lo + ((hi - lo) >> 1);
        if (lo >= hi) begin
          lvl <= lvl_inc;
        end
      end
      sals_pkg::S_SCOMP: begin
        if (cmp_eq) begin
          found <= 1'b1;
        end else if (!cmp_le) begin
          hi <= mid;
        end else begin
          lo <= mid + ONE;
        end
      end
      default: ;
    endcase
  end

  // RAM control and handshake outputs.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = LEVELS'(base_tgt + k);
    st_wdata = bf_rdata;
    st_raddr = LEVELS'(base + x);
    bf_we    = 1'b0;
    bf_waddr = {~cur, k[LEVELS-1:0]};
    bf_wdata = take ? st_rdata : bf_rdata;
    bf_raddr = {cur, y[LEVELS-1:0]};
    unique case (state)
      sals_pkg::S_INIT: begin
        bf_we    = 1'b1;
        bf_waddr = '0;
        bf_wdata = key;
      end
      sals_pkg::S_MCOMP: bf_we = 1'b1;
      sals_pkg::S_CREAD: bf_raddr = {cur, k[LEVELS-1:0]};
      sals_pkg::S_CWRITE: st_we = 1'b1;
      sals_pkg::S_SREAD: st_raddr = LEVELS'(base + lo + ((hi - lo) >> 1));
      default: ;
    endcase
  end

  assign in_ready      = (state == sals_pkg::S_IDLE);
  assign res_valid     = (state == sals_pkg::S_DONE) && out_free;
  assign res.found     = found;
  assign res.status    = status;
  assign res.key_count = sals_pkg::COUNT_W'(occ);

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    state == sals_pkg::S_MCOMP |-> (x <= n) && (y <= n))
    else $error("merge index ran past its level");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == sals_pkg::S_SCOMP |-> (mid < n))
    else $error("binary search probe outside its level");
  a_refused: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> !res.found && (&occ))
    else $error("refusal reported while a level was free");

endmodule

// ===== design/sorted_array_levels_set_top.sv =====
// Top level of the sorted-array levels set: stream ports, output register, RAMs.
// Depends on sals_pkg, sals_ram and sals_engine.
//
// Usage. One beat on the s_ side carries an operation: s_tuser is the function
// (0 insert, 1 search) and s_tdata the signed 32-bit key. Every beat gives
// exactly one beat on the m_ side with found, status and the key count.
// The block takes one operation at a time; s_tready is high only while the
// sequencer is idle. A search skips empty levels and binary-searches each
// full level, where each probe of the binary search needs one read of
// the level store and one compare; a hit ends it early.
// An insert that ends at free level j merges the levels below j with the
// new key, each key merged taking level store and merge buffer reads and
// one compare; it then copies each key back to level j with a buffer read
// and a store write. A refused insert, when every level is full, returns
// status 1 and leaves the set unchanged.
// Reset empties every level at once through the occupancy mask; the RAMs
// need no clearing. If the receiver stalls, the result waits in the output
// register and the next operation may already be accepted, but the sequencer
// holds its next result until the register is free.
module sorted_array_levels_set_top #(
  parameter int unsigned LEVELS = sals_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[31:0]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // found, status, key_count[9:0], zero pad
);

  localparam int unsigned STORE_DEPTH = (1 << LEVELS) - 1;
  localparam int unsigned BUF_DEPTH   = 2 << LEVELS;

  logic out_free;
  logic res_valid;
  sals_pkg::result_t res, res_q;

  logic st_we, bf_we;
  logic [LEVELS-1:0] st_waddr, st_raddr;
  logic [LEVELS:0]   bf_waddr, bf_raddr;
  logic [31:0] st_wdata, st_rdata, bf_wdata, bf_rdata;

  assign out_free = !m_tvalid || m_tready;

  sals_engine #(.LEVELS(LEVELS)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_key   (s_tdata),
    .in_ready (s_tready),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .bf_we    (bf_we),
    .bf_waddr (bf_waddr),
    .bf_wdata (bf_wdata),
    .bf_raddr (bf_raddr),
    .bf_rdata (bf_rdata)
  );

  // Level i lives at words 2^i-1 up to 2^(i+1)-2 of the level store.
  sals_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH), .AW(LEVELS)) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  // Two halves that take turns as source and destination of each merge.
  sals_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH), .AW(LEVELS + 1)) u_buf (
    .clk  (clk),
    .we   (bf_we),
    .waddr(bf_waddr),
    .wdata(bf_wdata),
    .raddr(bf_raddr),
    .rdata(bf_rdata)
  );

  // Output register: holds a result beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {4'b0000, res_q.key_count, res_q.status, res_q.found};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !res_valid)
    else $error("result beat overwritten while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second operation accepted while busy");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("found and refusal both set");

endmodule

// ===== dv/sorted_array_levels_set_top_test.sv =====
// Self-checking bench for the sorted-array levels set top level.
// Depends on sals_pkg and the RTL of sorted_array_levels_set_top.
module sorted_array_levels_set_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NLEV   = 10;
  localparam int unsigned FULL_N = (1 << NLEV) - 1;
  localparam int unsigned N_RAND = 1130;
  localparam longint     LIMIT  = 4000000;

  typedef struct packed {
    logic                         found;
    logic                         status;
    logic [sals_pkg::COUNT_W-1:0] key_count;
  } outcome_t;

  typedef struct {
    logic        func;
    logic [31:0] key;
    logic        known;   // expected result is typed in below
    outcome_t    res;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  sorted_array_levels_set_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow of the stored multiset: the keys themselves and the level mask.
  // Searching a multiset needs no level structure, only membership.
  logic [NLEV-1:0] shadow_mask;
  int              shadow_keys[logic [31:0]];
  outcome_t        pending_results[$];
  bit              failed = 1'b0;
  bit              hold_req = 1'b0;
  longint          cyc = 0;

  function automatic outcome_t apply_op(logic func, logic [31:0] key);
    outcome_t r;
    r = '0;
    if (func == sals_pkg::FUNC_INSERT) begin
      if (&shadow_mask) r.status = 1'b1;
      else begin
        shadow_mask = shadow_mask + NLEV'(1);   // binary carry, exactly as levels merge
        if (shadow_keys.exists(key)) shadow_keys[key]++;
        else shadow_keys[key] = 1;
      end
    end else begin
      r.found = (shadow_keys.exists(key) != 0);
    end
    r.key_count = sals_pkg::COUNT_W'(shadow_mask);
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter doubles as the timeout watchdog.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The valid line is dropped only when a gap follows, so that it never
  // takes two assignments at one falling edge.
  task automatic send_op(logic func, logic [31:0] key, bit known, outcome_t res);
    outcome_t want;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    want = apply_op(func, key);
    if (known && want !== res) begin
      $error("table row disagrees with predictor: key %h exp %h got %h", key, res, want);
      failed = 1'b1;
    end
    pending_results = {pending_results, want};
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= key;
    do @(posedge clk); while (!(s_tready === 1'b1));
    @(negedge clk);
  endtask

  function automatic outcome_t mk(logic f, logic s, int n);
    outcome_t r;
    r.found = f; r.status = s; r.key_count = sals_pkg::COUNT_W'(n);
    return r;
  endfunction

  // Receiver: random stalls per beat; one long hold-off when asked.
  initial begin
    int stall;
    bit hold_done;
    outcome_t got, want;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 4);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.found     = m_tdata[0];
      got.status    = m_tdata[1];
      got.key_count = m_tdata[sals_pkg::COUNT_W+1:2];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d actual %0d", want.found, got.found);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.key_count !== want.key_count) begin
          $error("key_count: expected %0d actual %0d", want.key_count, got.key_count);
          failed = 1'b1;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    op_row_t table_rows [17];
    logic [31:0] pool[$];
    logic [31:0] k;
    int mode, fill_left;
    shadow_mask = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty-set search, extremes of the key, duplicates.
    table_rows = '{
      '{sals_pkg::FUNC_SEARCH, 32'h0000_0000, 1'b1, mk(0, 0, 0)},
      '{sals_pkg::FUNC_SEARCH, 32'h8000_0000, 1'b1, mk(0, 0, 0)},
      '{sals_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, mk(0, 0, 1)},
      '{sals_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, mk(0, 0, 2)},
      '{sals_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, mk(0, 0, 3)},
      '{sals_pkg::FUNC_INSERT, 32'h0000_0000, 1'b1, mk(0, 0, 4)},
      '{sals_pkg::FUNC_INSERT, 32'h0000_0000, 1'b1, mk(0, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'h8000_0000, 1'b1, mk(1, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'h7FFF_FFFF, 1'b1, mk(1, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, 1'b1, mk(1, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'h0000_0000, 1'b1, mk(1, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'h8000_0001, 1'b1, mk(0, 0, 5)},
      '{sals_pkg::FUNC_SEARCH, 32'h7FFF_FFFE, 1'b1, mk(0, 0, 5)},
      '{sals_pkg::FUNC_INSERT, 32'h5555_AAAA, 1'b0, '0},
      '{sals_pkg::FUNC_INSERT, 32'hAAAA_5555, 1'b0, '0},
      '{sals_pkg::FUNC_INSERT, 32'h8000_0000, 1'b0, '0},
      '{sals_pkg::FUNC_SEARCH, 32'hAAAA_5555, 1'b0, '0}
    };
    foreach (table_rows[i])
      send_op(table_rows[i].func, table_rows[i].key, table_rows[i].known, table_rows[i].res);
    s_tvalid <= 1'b0;
    pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h5555_AAAA};

    // Sender pauses until every expected beat has drained.
    while (pending_results.size() != 0) @(negedge clk);

    // Receiver holds off while the sender keeps offering beats.
    hold_req = 1'b1;

    // Random part: searches mostly hit known keys, keys often small-range so
    // duplicates and near-misses arise. Early on the set is filled to the top
    // so that refused inserts and full-depth searches are exercised.
    fill_left = 0;
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 8) fill_left = int'(FULL_N) - int'(shadow_mask);
      mode = $urandom_range(0, 9);
      if (fill_left > 0 || mode < 5) begin
        if (mode < 3) k = $urandom();
        else if (mode < 6) k = $urandom_range(0, 63) - 32;
        else k = pool[$urandom_range(0, pool.size() - 1)] + $urandom_range(0, 2) - 1;
        pool = {pool, k};
        if (fill_left > 0) fill_left--;
        send_op(sals_pkg::FUNC_INSERT, k, 0, '0);
        if (fill_left == 1 && (&shadow_mask)) fill_left = 0;
      end else begin
        if (mode < 8) k = pool[$urandom_range(0, pool.size() - 1)];
        else k = $urandom();
        send_op(sals_pkg::FUNC_SEARCH, k, 0, '0);
      end
    end
    // A few refused inserts if the set happens to be full now.
    repeat (3) send_op(sals_pkg::FUNC_INSERT, $urandom(), 0, '0);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
